@@ design/spi_pkg.sv @@
package spi_pkg;

    typedef enum logic [2:0] {
        CMD_LD_TGT  = 3'd0,
        CMD_LD_MEAS = 3'd1,
        CMD_LD_LIM  = 3'd2,
        CMD_START   = 3'd3,
        CMD_TICK    = 3'd4
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE,
        S_FRM,
        S_SRD,
        S_SGO,
        S_SWAIT,
        S_TRD,
        S_TGO,
        S_ERD,
        S_EOUT
    } t_state;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [5:0]  servo_id;
        logic [15:0] position;
        logic [11:0] limit_low;
        logic [11:0] limit_high;
        logic [15:0] move_time;
    } t_in_word;

    typedef struct packed {
        logic [5:0]  out_servo_id;
        logic [11:0] out_position;
        logic        last;
        logic        moving;
    } t_out_word;

    typedef struct packed {
        logic load;
        logic frm_go;
        logic frames_ld;
        logic sdiv_go;
        logic step_wr;
        logic tick_begin;
        logic tick_wr;
        logic flag_set;
        logic flag_eval;
        logic idx_clr;
        logic idx_inc;
        logic out_ld;
    } t_ctl;

    typedef struct packed {
        logic div_busy;
        logic div_done;
        logic idx_last;
        logic out_free;
        logic moving;
    } t_sts;

    localparam logic [3:0]  DIV_STEPS  = 4'd15;
    localparam logic [11:0] NARROW_MAX = 12'd1023;
    localparam logic [11:0] WIDE_MAX   = 12'd4095;
    localparam logic [11:0] NARROW_MID = 12'd512;
    localparam logic [11:0] WIDE_MID   = 12'd2048;
    localparam logic [15:0] POS_INVALID = 16'hFFFF;
    localparam logic [9:0]  FRAME_LEN_RESET = 10'd33;
    localparam logic        REG_FRAME_LEN = 1'b0;

    // true when v is a multiple of three (base-4 digit sum)
    function automatic logic f_mod3_zero(input logic [5:0] v);
        logic [3:0] s;
        s = {2'b00, v[5:4]} + {2'b00, v[3:2]} + {2'b00, v[1:0]};
        return (s == 4'd0) || (s == 4'd3) || (s == 4'd6) || (s == 4'd9);
    endfunction

endpackage

@@ design/spi_ram.sv @@
module spi_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 18
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ design/spi_div.sv @@
module spi_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_go,
    input  logic [15:0] i_dividend,
    input  logic [16:0] i_divisor,
    output logic [15:0] o_quot,
    output logic        o_busy,
    output logic        o_done
);
    // restoring divider, one quotient bit a cycle
    logic [16:0] r_rem;
    logic [15:0] r_quo;
    logic [16:0] r_div;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [17:0] sh;
    logic        take;
    logic [17:0] diff;

    always_comb begin
        sh   = {r_rem, r_quo[15]};
        diff = sh - {1'b0, r_div};
        take = (sh >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= spi_pkg::DIV_STEPS;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 4'd1;
                if (r_cnt == 4'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= take ? diff[16:0] : sh[16:0];
            r_quo <= {r_quo[14:0], take};
        end
    end

    assign o_quot = r_quo;
    assign o_busy = r_busy;
    assign o_done = r_done;
endmodule

@@ design/spi_ctrl.sv @@
module spi_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [2:0]    i_cmd,
    input  spi_pkg::t_sts i_sts,
    output logic          o_in_stall,
    output spi_pkg::t_ctl o_ctl
);
    spi_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= spi_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            spi_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    case (i_cmd)
                        spi_pkg::CMD_LD_TGT, spi_pkg::CMD_LD_MEAS,
                        spi_pkg::CMD_LD_LIM: begin
                            o_ctl.load = 1'b1;
                        end
                        spi_pkg::CMD_START: begin
                            o_ctl.frm_go = 1'b1;
                            n_state      = spi_pkg::S_FRM;
                        end
                        spi_pkg::CMD_TICK: begin
                            if (i_sts.moving) begin
                                o_ctl.tick_begin = 1'b1;
                                o_ctl.idx_clr    = 1'b1;
                                n_state          = spi_pkg::S_TRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            spi_pkg::S_FRM: begin
                if (i_sts.div_done) begin
                    o_ctl.frames_ld = 1'b1;
                    o_ctl.idx_clr   = 1'b1;
                    n_state         = spi_pkg::S_SRD;
                end
            end
            spi_pkg::S_SRD: n_state = spi_pkg::S_SGO;
            spi_pkg::S_SGO: begin
                o_ctl.sdiv_go = 1'b1;
                n_state       = spi_pkg::S_SWAIT;
            end
            spi_pkg::S_SWAIT: begin
                if (i_sts.div_done) begin
                    o_ctl.step_wr = 1'b1;
                    if (i_sts.idx_last) begin
                        o_ctl.flag_set = 1'b1;
                        n_state        = spi_pkg::S_IDLE;
                    end else begin
                        o_ctl.idx_inc = 1'b1;
                        n_state       = spi_pkg::S_SRD;
                    end
                end
            end
            spi_pkg::S_TRD: n_state = spi_pkg::S_TGO;
            spi_pkg::S_TGO: begin
                o_ctl.tick_wr = 1'b1;
                if (i_sts.idx_last) begin
                    o_ctl.flag_eval = 1'b1;
                    o_ctl.idx_clr   = 1'b1;
                    n_state         = spi_pkg::S_ERD;
                end else begin
                    o_ctl.idx_inc = 1'b1;
                    n_state       = spi_pkg::S_TRD;
                end
            end
            spi_pkg::S_ERD: n_state = spi_pkg::S_EOUT;
            spi_pkg::S_EOUT: begin
                if (i_sts.out_free) begin
                    o_ctl.out_ld = 1'b1;
                    if (i_sts.idx_last) begin
                        n_state = spi_pkg::S_IDLE;
                    end else begin
                        o_ctl.idx_inc = 1'b1;
                        n_state       = spi_pkg::S_ERD;
                    end
                end
            end
            default: n_state = spi_pkg::S_IDLE;
        endcase
    end

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.out_ld |-> i_sts.out_free) else $error("word loaded over a held word");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ctl.frm_go || o_ctl.sdiv_go) |-> !i_sts.div_busy)
        else $error("divider started while busy");
    a_emit_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == spi_pkg::S_TGO && i_sts.idx_last) |=> r_state == spi_pkg::S_ERD)
        else $error("update pass not followed by emit pass");
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.step_wr |-> i_sts.div_done) else $error("step written before quotient");
endmodule

@@ design/spi_dp.sv @@
module spi_dp #(
    parameter int POSE_SIZE = 18
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spi_pkg::t_ctl     i_ctl,
    output spi_pkg::t_sts     o_sts,
    input  spi_pkg::t_in_word i_in,
    input  logic [9:0]        i_frame_len,
    output spi_pkg::t_out_word o_out,
    output logic              o_out_valid,
    input  logic              i_out_stall
);
    localparam int IW = $clog2(POSE_SIZE);
    localparam logic [IW-1:0] LAST_IDX = IW'(POSE_SIZE - 1);

    logic [IW-1:0]        r_idx;
    logic [1:0]           r_m3;
    logic [POSE_SIZE-1:0] r_v_cur, r_v_tgt, r_v_step, r_v_lim;
    logic [16:0]          r_frames;
    logic                 r_dneg, r_dzero;
    logic                 r_all_arr;
    logic                 r_moving;
    spi_pkg::t_out_word   r_out;
    logic                 r_out_valid;

    // load decode
    logic [5:0]    id_m1;
    logic          id_ok;
    logic [IW-1:0] ld_addr;
    logic          ld_narrow;
    logic [11:0]   ld_max;
    logic [11:0]   tgt_ld, cur_ld;
    logic          we_tgt, we_meas, we_lim;

    // ram ports
    logic          we_cur;
    logic [IW-1:0] wa_cur, wa_tgt, wa_lim;
    logic [11:0]   wd_cur;
    logic [11:0]   rd_cur, rd_tgt;
    logic [13:0]   rd_step, wd_step;
    logic [23:0]   rd_lim;

    // read side with reset values
    logic          narrow;
    logic [11:0]   mid, tmax;
    logic [11:0]   cur_v, tgt_v, lo_v, hi_v;
    logic signed [13:0] step_v;
    logic signed [12:0] d;
    logic [11:0]   ad;
    logic [13:0]   as_mag;
    logic          toward, gt, arrived;
    logic signed [13:0] half;
    logic signed [15:0] nxt;
    logic [11:0]   new_cur;
    logic [11:0]   emit_pos;

    // divider
    logic          div_go, div_busy, div_done;
    logic [15:0]   div_q, div_n;
    logic [16:0]   div_d;
    logic [9:0]    fl_eff;
    logic [12:0]   smag;

    always_comb begin
        id_m1     = i_in.servo_id - 6'd1;
        id_ok     = (i_in.servo_id != 6'd0) && (i_in.servo_id <= 6'(POSE_SIZE));
        ld_addr   = id_m1[IW-1:0];
        ld_narrow = spi_pkg::f_mod3_zero(id_m1);
        ld_max    = ld_narrow ? spi_pkg::NARROW_MAX : spi_pkg::WIDE_MAX;
        tgt_ld    = (i_in.position > {4'd0, ld_max}) ? ld_max : i_in.position[11:0];
        cur_ld    = (i_in.position > {4'd0, spi_pkg::WIDE_MAX}) ? spi_pkg::WIDE_MAX
                                                                : i_in.position[11:0];
        we_tgt  = i_ctl.load && id_ok && (i_in.cmd == spi_pkg::CMD_LD_TGT);
        we_meas = i_ctl.load && id_ok && (i_in.cmd == spi_pkg::CMD_LD_MEAS)
                  && (i_in.position != spi_pkg::POS_INVALID);
        we_lim  = i_ctl.load && id_ok && (i_in.cmd == spi_pkg::CMD_LD_LIM);
        we_cur  = we_meas || i_ctl.tick_wr;
        wa_cur  = i_ctl.tick_wr ? r_idx : ld_addr;
        wd_cur  = i_ctl.tick_wr ? new_cur : cur_ld;
        wa_tgt  = ld_addr;
        wa_lim  = ld_addr;
    end

    spi_ram #(.WIDTH(12), .DEPTH(POSE_SIZE)) u_cur (
        .i_clk(i_clk), .i_we(we_cur), .i_waddr(wa_cur), .i_wdata(wd_cur),
        .i_raddr(r_idx), .o_rdata(rd_cur)
    );
    spi_ram #(.WIDTH(12), .DEPTH(POSE_SIZE)) u_tgt (
        .i_clk(i_clk), .i_we(we_tgt), .i_waddr(wa_tgt), .i_wdata(tgt_ld),
        .i_raddr(r_idx), .o_rdata(rd_tgt)
    );
    spi_ram #(.WIDTH(14), .DEPTH(POSE_SIZE)) u_step (
        .i_clk(i_clk), .i_we(i_ctl.step_wr), .i_waddr(r_idx), .i_wdata(wd_step),
        .i_raddr(r_idx), .o_rdata(rd_step)
    );
    spi_ram #(.WIDTH(24), .DEPTH(POSE_SIZE)) u_lim (
        .i_clk(i_clk), .i_we(we_lim), .i_waddr(wa_lim),
        .i_wdata({i_in.limit_high, i_in.limit_low}),
        .i_raddr(r_idx), .o_rdata(rd_lim)
    );

    always_comb begin
        narrow = (r_m3 == 2'd0);
        mid    = narrow ? spi_pkg::NARROW_MID : spi_pkg::WIDE_MID;
        tmax   = narrow ? spi_pkg::NARROW_MAX : spi_pkg::WIDE_MAX;
        cur_v  = r_v_cur[r_idx] ? rd_cur : mid;
        tgt_v  = r_v_tgt[r_idx] ? rd_tgt : mid;
        step_v = r_v_step[r_idx] ? $signed(rd_step) : 14'sd0;
        lo_v   = r_v_lim[r_idx] ? rd_lim[11:0] : 12'd0;
        hi_v   = r_v_lim[r_idx] ? rd_lim[23:12] : spi_pkg::WIDE_MAX;

        d      = $signed({1'b0, tgt_v}) - $signed({1'b0, cur_v});
        ad     = d[12] ? 12'(-d) : d[11:0];
        as_mag = step_v[13] ? 14'(-step_v) : 14'(step_v);
        gt     = {2'b00, ad} > as_mag;
        toward = (!d[12] && (d != 13'sd0) && !step_v[13] && (step_v != 14'sd0))
                 || (d[12] && step_v[13]);
        half   = (step_v + (step_v[13] ? 14'sd1 : 14'sd0)) >>> 1;
        arrived = (d == 13'sd0) || !gt;

        if (d == 13'sd0) begin
            nxt = $signed({4'd0, cur_v});
        end else if (gt) begin
            if (toward) begin
                nxt = $signed({4'd0, cur_v}) + 16'(step_v);
            end else begin
                nxt = $signed({4'd0, cur_v}) - 16'(half);
            end
        end else begin
            nxt = $signed({4'd0, tgt_v});
        end
        if (nxt[15]) begin
            new_cur = 12'd0;
        end else if (nxt > $signed({4'd0, tmax})) begin
            new_cur = tmax;
        end else begin
            new_cur = nxt[11:0];
        end

        if (cur_v < lo_v) begin
            emit_pos = lo_v;
        end else if (cur_v > hi_v) begin
            emit_pos = hi_v;
        end else begin
            emit_pos = cur_v;
        end

        fl_eff = (i_frame_len == 10'd0) ? 10'd1 : i_frame_len;
        div_go = i_ctl.frm_go || i_ctl.sdiv_go;
        div_n  = i_ctl.sdiv_go ? {4'd0, ad} : i_in.move_time;
        div_d  = i_ctl.sdiv_go ? r_frames : {7'd0, fl_eff};
        smag   = {1'b0, div_q[11:0]} + 13'd1;
        wd_step = r_dzero ? 14'd0 : (r_dneg ? 14'(-{1'b0, smag}) : {1'b0, smag});
    end

    spi_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(div_go), .i_dividend(div_n),
        .i_divisor(div_d), .o_quot(div_q), .o_busy(div_busy), .o_done(div_done)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_m3        <= '0;
            r_v_cur     <= '0;
            r_v_tgt     <= '0;
            r_v_step    <= '0;
            r_v_lim     <= '0;
            r_all_arr   <= 1'b0;
            r_moving    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ctl.idx_clr) begin
                r_idx <= '0;
                r_m3  <= '0;
            end else if (i_ctl.idx_inc) begin
                r_idx <= r_idx + 1'b1;
                r_m3  <= (r_m3 == 2'd2) ? 2'd0 : r_m3 + 2'd1;
            end
            if (we_cur)        r_v_cur[wa_cur]  <= 1'b1;
            if (we_tgt)        r_v_tgt[wa_tgt]  <= 1'b1;
            if (we_lim)        r_v_lim[wa_lim]  <= 1'b1;
            if (i_ctl.step_wr) r_v_step[r_idx]  <= 1'b1;
            if (i_ctl.tick_begin) begin
                r_all_arr <= 1'b1;
            end else if (i_ctl.tick_wr && !arrived) begin
                r_all_arr <= 1'b0;
            end
            if (i_ctl.flag_set) begin
                r_moving <= 1'b1;
            end else if (i_ctl.flag_eval) begin
                r_moving <= !(r_all_arr && arrived);
            end
            if (i_ctl.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.frames_ld) begin
            r_frames <= {1'b0, div_q} + 17'd1;
        end
        if (i_ctl.sdiv_go) begin
            r_dneg  <= d[12];
            r_dzero <= (d == 13'sd0);
        end
        if (i_ctl.out_ld) begin
            r_out.out_servo_id <= 6'(r_idx) + 6'd1;
            r_out.out_position <= emit_pos;
            r_out.last         <= (r_idx == LAST_IDX);
            r_out.moving       <= r_moving;
        end
    end

    assign o_out       = r_out;
    assign o_out_valid = r_out_valid;
    assign o_sts.div_busy = div_busy;
    assign o_sts.div_done = div_done;
    assign o_sts.idx_last = (r_idx == LAST_IDX);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;
    assign o_sts.moving   = r_moving;
endmodule

@@ design/servo_pose_interpolator.sv @@
// keyframe pose interpolator for a bank of POSE_SIZE servos
// input channel (i_in_valid / o_in_stall) takes one command word: load target,
// load measured position, load limits, start move or frame tick
// output channel (o_out_valid / i_out_stall) gives one word per servo on a
// frame tick while a move is in progress, last set on the final servo
// loads do not stall; the block takes a new word in the next cycle
// on start a 16-step serial divider forms the frame count, then one division per servo
// a tick updates every servo through the single read port of each store,
// then emits the words in a second pass;
// a stalled receiver holds the output register and the emit pass waits on it
// only one word is in work at a time; o_in_stall is high until it is done
// reset: all servos mid-range (512 narrow, 2048 wide), limits 0..4095, zero
// step, not moving, frame length 33 ms; stores need no clearing pass
// frame length is written over the apb port at byte address 0
module servo_pose_interpolator #(
    parameter int POSE_SIZE = 18
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // command words
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spi_pkg::t_in_word  i_in_word,
    // servo position words
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spi_pkg::t_out_word o_out_word,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic [9:0]    r_frame_len;
    spi_pkg::t_ctl ctl;
    spi_pkg::t_sts sts;

    // frame length register, decoded on the word address bit only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= spi_pkg::FRAME_LEN_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == spi_pkg::REG_FRAME_LEN)) begin
            r_frame_len <= pwdata[9:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == spi_pkg::REG_FRAME_LEN) ? {22'd0, r_frame_len} : 32'd0;

    // sequencer: walks servos for start, update and emit passes
    spi_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_cmd(i_in_word.cmd), .i_sts(sts), .o_in_stall(o_in_stall), .o_ctl(ctl)
    );

    // pose stores, divider, step arithmetic and output register
    spi_dp #(.POSE_SIZE(POSE_SIZE)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_ctl(ctl), .o_sts(sts),
        .i_in(i_in_word), .i_frame_len(r_frame_len), .o_out(o_out_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall)
    );
endmodule

@@ tb/tb_servo_pose_interpolator.sv @@
`timescale 1ns / 1ps

module tb_servo_pose_interpolator;

    localparam int N_SERVO = 18;
    localparam int WATCHDOG_LIMIT = 20000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    spi_pkg::t_in_word    i_in_word = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    spi_pkg::t_out_word   o_out_word;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;

    servo_pose_interpolator #(.POSE_SIZE(N_SERVO)) DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #6 i_clk = ~i_clk;

    // shadow copy of the servo bank
    int        cur_pos [N_SERVO];
    int        tgt_pos [N_SERVO];
    int        step_sz [N_SERVO];
    int        lim_lo  [N_SERVO];
    int        lim_hi  [N_SERVO];
    bit        is_moving;
    int        frame_len;

    spi_pkg::t_out_word servo_words_due[$];
    int        n_fail;
    int        idle_cycles;
    int        rx_mode;

    function automatic int range_top(int idx);
        return (idx % 3 == 0) ? 1023 : 4095;
    endfunction

    function automatic int clip(int v, int lo, int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // apply one command word to the shadow bank, queue any servo words
    function automatic void predict_pose(spi_pkg::t_in_word w);
        int idx, frames, fl, d, s, ad, as_, c, pending, p;
        bit ok;
        spi_pkg::t_out_word o;
        ok  = (w.servo_id >= 1) && (w.servo_id <= N_SERVO);
        idx = ok ? int'(w.servo_id) - 1 : 0;
        case (w.cmd)
            spi_pkg::CMD_LD_TGT: if (ok) tgt_pos[idx] = clip(int'(w.position), 0, range_top(idx));
            spi_pkg::CMD_LD_MEAS: if (ok && w.position != spi_pkg::POS_INVALID)
                cur_pos[idx] = (w.position > 4095) ? 4095 : int'(w.position);
            spi_pkg::CMD_LD_LIM: if (ok) begin
                lim_lo[idx] = w.limit_low;
                lim_hi[idx] = w.limit_high;
            end
            spi_pkg::CMD_START: begin
                fl = (frame_len == 0) ? 1 : frame_len;
                frames = int'(w.move_time) / fl + 1;
                for (int i = 0; i < N_SERVO; i++) begin
                    d = tgt_pos[i] - cur_pos[i];
                    if (d > 0) s = d / frames + 1;
                    else if (d < 0) s = d / frames - 1;
                    else s = 0;
                    step_sz[i] = s;
                end
                is_moving = 1'b1;
            end
            spi_pkg::CMD_TICK: if (is_moving) begin
                pending = N_SERVO;
                for (int i = 0; i < N_SERVO; i++) begin
                    c = cur_pos[i];
                    d = tgt_pos[i] - c;
                    s = step_sz[i];
                    ad = d < 0 ? -d : d;
                    as_ = s < 0 ? -s : s;
                    if (d == 0) pending--;
                    else if (ad > as_) begin
                        if ((d > 0 && s > 0) || (d < 0 && s < 0)) c += s;
                        else c -= s / 2;
                    end else begin
                        c = tgt_pos[i];
                        pending--;
                    end
                    cur_pos[i] = clip(c, 0, range_top(i));
                end
                if (pending <= 0) is_moving = 1'b0;
                for (int i = 0; i < N_SERVO; i++) begin
                    p = cur_pos[i];
                    if (p < lim_lo[i]) p = lim_lo[i];
                    else if (p > lim_hi[i]) p = lim_hi[i];
                    o.out_servo_id = 6'(i + 1);
                    o.out_position = 12'(p);
                    o.last = (i == N_SERVO - 1);
                    o.moving = is_moving;
                    servo_words_due.push_back(o);
                end
            end
            default: ;
        endcase
    endfunction

    // send one command word, then maybe a random gap
    task automatic send_word(spi_pkg::t_in_word w, int gap);
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        predict_pose(w);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drop_valid();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // wait for every servo word and an idle block, then let it settle
    task automatic drain();
        drop_valid();
        while (servo_words_due.size() != 0 || o_in_stall) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // apb write; block must be idle
    task automatic write_frame_len(int v);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= 3'(4 * int'(spi_pkg::REG_FRAME_LEN)); pwdata <= 32'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        frame_len = v & 32'h3FF;
        @(posedge i_clk);
    endtask

    function automatic spi_pkg::t_in_word mk(spi_pkg::t_cmd c, int id, int pos, int lo,
                                             int hi, int mt);
        spi_pkg::t_in_word w;
        w.cmd = c; w.servo_id = 6'(id); w.position = 16'(pos);
        w.limit_low = 12'(lo); w.limit_high = 12'(hi); w.move_time = 16'(mt);
        return w;
    endfunction

    function automatic spi_pkg::t_in_word rand_word();
        spi_pkg::t_in_word w;
        w = spi_pkg::t_in_word'({1'($urandom), $urandom, $urandom});
        return w;
    endfunction

    function automatic int rgap();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    endfunction

    // checker for servo words
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (servo_words_due.size() == 0) begin
                $error("servo word with none expected: %h", o_out_word);
                n_fail++;
            end else begin
                spi_pkg::t_out_word e;
                e = servo_words_due.pop_front();
                if (o_out_word.out_servo_id !== e.out_servo_id) begin
                    $error("out_servo_id exp %0d got %0d", e.out_servo_id, o_out_word.out_servo_id);
                    n_fail++;
                end
                if (o_out_word.out_position !== e.out_position) begin
                    $error("out_position exp %0d got %0d", e.out_position, o_out_word.out_position);
                    n_fail++;
                end
                if (o_out_word.last !== e.last) begin
                    $error("last exp %0b got %0b", e.last, o_out_word.last);
                    n_fail++;
                end
                if (o_out_word.moving !== e.moving) begin
                    $error("moving exp %0b got %0b", e.moving, o_out_word.moving);
                    n_fail++;
                end
            end
        end
    end

    // receiver stall pattern: none, sparse, heavy, long bursts
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) rx_mode <= $urandom_range(0, 3);
        case (rx_mode)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 7) == 0);
            2: i_out_stall <= ($urandom_range(0, 1) == 0);
            default: i_out_stall <= ($urandom_range(0, 15) < 13);
        endcase
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else if (i_rst_n) begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("tb_servo_pose_interpolator failed");
                $finish;
            end
        end
    end

    task automatic test_reset_frame();
        // tick while idle gives nothing, then start from reset pose
        send_word(mk(spi_pkg::CMD_TICK, 0, 0, 0, 0, 0), 0);
        send_word(mk(spi_pkg::CMD_START, 0, 0, 0, 0, 0), 0);
        send_word(mk(spi_pkg::CMD_TICK, 0, 0, 0, 0, 0), 0);
        drain();
    endtask

    task automatic test_directed();
        send_word(mk(spi_pkg::CMD_LD_TGT, 1, 65535, 0, 0, 0), 0);   // narrow clamp
        send_word(mk(spi_pkg::CMD_LD_TGT, 2, 5000, 0, 0, 0), 0);    // wide clamp
        send_word(mk(spi_pkg::CMD_LD_TGT, 3, 0, 0, 0, 0), 1);
        send_word(mk(spi_pkg::CMD_LD_TGT, 0, 100, 0, 0, 0), 0);     // bad id
        send_word(mk(spi_pkg::CMD_LD_TGT, 63, 100, 0, 0, 0), 0);
        send_word(mk(spi_pkg::CMD_LD_MEAS, 3, 65535, 0, 0, 0), 0);  // invalid reading
        send_word(mk(spi_pkg::CMD_LD_MEAS, 4, 60000, 0, 0, 0), 0);  // saturate
        send_word(mk(spi_pkg::CMD_LD_MEAS, 18, 0, 0, 0, 0), 0);
        send_word(mk(spi_pkg::CMD_LD_LIM, 2, 0, 4095, 0, 0), 2);    // crossed limits
        send_word(mk(spi_pkg::CMD_LD_LIM, 5, 0, 100, 200, 0), 0);
        send_word(mk(spi_pkg::CMD_LD_LIM, 19, 0, 1, 2, 0), 0);
        send_word(mk(spi_pkg::t_cmd'(3'd5), 1, 0, 0, 0, 0), 0);     // unknown codes
        send_word(mk(spi_pkg::t_cmd'(3'd7), 1, 0, 0, 0, 0), 0);
        send_word(mk(spi_pkg::CMD_START, 0, 0, 0, 0, 65535), 0);    // long move
        for (int i = 0; i < 3; i++) send_word(mk(spi_pkg::CMD_TICK, 0, 0, 0, 0, 0), rgap());
        send_word(mk(spi_pkg::CMD_START, 0, 0, 0, 0, 0), 0);        // one frame
        for (int i = 0; i < 4; i++) send_word(mk(spi_pkg::CMD_TICK, 0, 0, 0, 0, 0), 0);
        drain();
    endtask

    // well-formed moves with random content, plus some noise
    task automatic test_random_moves(int n_words);
        int sent;
        int ticks;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(0, 9) == 0) begin
                send_word(rand_word(), rgap());
                sent++;
                continue;
            end
            repeat ($urandom_range(1, 6)) begin
                send_word(mk(spi_pkg::t_cmd'($urandom_range(0, 2)), $urandom_range(0, 20),
                    ($urandom_range(0, 5) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095),
                    0), rgap());
                sent++;
            end
            send_word(mk(spi_pkg::CMD_START, 0, 0, 0, 0,
                ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                            : $urandom_range(0, 300)), rgap());
            sent++;
            ticks = $urandom_range(1, 8);
            repeat (ticks) begin
                send_word(mk(spi_pkg::CMD_TICK, 0, 0, 0, 0, 0), rgap());
                sent++;
            end
            // hold off now and then until every servo word has arrived
            if ($urandom_range(0, 5) == 0) begin
                drop_valid();
                while (servo_words_due.size() != 0) @(posedge i_clk);
            end
        end
        drain();
    endtask

    task automatic test_frame_len(int v, int n_words);
        write_frame_len(v);
        test_random_moves(n_words);
    endtask

    initial begin
        n_fail = 0;
        idle_cycles = 0;
        rx_mode = 0;
        for (int i = 0; i < N_SERVO; i++) begin
            cur_pos[i] = (i % 3 == 0) ? 512 : 2048;
            tgt_pos[i] = cur_pos[i];
            step_sz[i] = 0;
            lim_lo[i] = 0;
            lim_hi[i] = 4095;
        end
        is_moving = 1'b0;
        frame_len = spi_pkg::FRAME_LEN_RESET;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_frame();
        test_directed();
        test_random_moves(120);
        test_frame_len(1, 90);
        test_frame_len(1000, 80);
        test_frame_len(0, 60);     // zero treated as one
        test_frame_len(1023, 40);
        test_frame_len($urandom_range(2, 999), 60);

        if (n_fail == 0)
            $display("tb_servo_pose_interpolator passed");
        else
            $display("tb_servo_pose_interpolator failed");
        $finish;
    end

endmodule
